/* hw/rtl/qah_pkg.sv */
package qah_pkg;

  localparam int COORD_W = 14;
  localparam int COORD_BITS_DEF = 14;
  localparam int AREA_W = 31;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

endpackage

/* hw/rtl/qah_sqrt_cell.sv */
module qah_sqrt_cell #(
  parameter int RW = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW:0]     rem_i,
  input  logic [RW-1:0]   root_i,
  output logic [2*RW-1:0] rad_o,
  output logic [RW:0]     rem_o,
  output logic [RW-1:0]   root_o
);

  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic [RW+3:0] diff;
  logic          ge;
  logic [2*RW-1:0] rad_r;
  logic [RW:0]     rem_r;
  logic [RW-1:0]   root_r;
  logic [2*RW-1:0] rad_nxt;
  logic [RW:0]     rem_nxt;
  logic [RW-1:0]   root_nxt;

  // one restoring step: bring down two radicand bits, try root*4+1
  assign rem_sh = {rem_i, rad_i[2*RW-1 -: 2]};
  assign trial  = {1'b0, root_i, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign ge     = ~diff[RW+3];

  assign rad_nxt  = {rad_i[2*RW-3:0], 2'b00};
  assign rem_nxt  = ge ? diff[RW:0] : rem_sh[RW:0];
  assign root_nxt = {root_i[RW-2:0], ge};

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

/* hw/rtl/qah_sqrt_chain.sv */
module qah_sqrt_chain #(
  parameter int RW = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW-1:0]   root_o
);

  logic [2*RW-1:0] rad_w  [RW+1];
  logic [RW:0]     rem_w  [RW+1];
  logic [RW-1:0]   root_w [RW+1];

  assign rad_w[0]  = rad_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    qah_sqrt_cell #(.RW(RW)) u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (rad_w[i]),
      .rem_i  (rem_w[i]),
      .root_i (root_w[i]),
      .rad_o  (rad_w[i+1]),
      .rem_o  (rem_w[i+1]),
      .root_o (root_w[i+1])
    );
  end

  assign root_o = root_w[RW];

endmodule

/* hw/rtl/quad_area_heron.sv */
// Quadrilateral area by Heron's formula, split along the diagonal from corner 1
// to corner 3. Fully pipelined: unless the output stalls, one word is accepted
// per cycle and one result leaves per cycle. The latency is set by the chain of
// square-root cells for the side lengths (one cell per root bit) followed by
// the chain for the triangle areas. The whole pipeline stalls while a result
// waits at the output.
module quad_area_heron #(
  parameter int COORD_BITS = qah_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [qah_pkg::COORD_W-1:0]  in_corner0_x,
  input  logic [qah_pkg::COORD_W-1:0]  in_corner0_y,
  input  logic [qah_pkg::COORD_W-1:0]  in_corner1_x,
  input  logic [qah_pkg::COORD_W-1:0]  in_corner1_y,
  input  logic [qah_pkg::COORD_W-1:0]  in_corner2_x,
  input  logic [qah_pkg::COORD_W-1:0]  in_corner2_y,
  input  logic [qah_pkg::COORD_W-1:0]  in_corner3_x,
  input  logic [qah_pkg::COORD_W-1:0]  in_corner3_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [qah_pkg::AREA_W-1:0]   out_area
);

  localparam int C     = COORD_BITS;
  localparam int SR    = C + 1;
  localparam int FW    = SR + 2;
  localparam int PR    = 2 * FW;
  localparam int DEPTH = 6 + SR + PR;
  localparam int SW    = (PR + 1 > qah_pkg::AREA_W + 1) ? PR + 1 : qah_pkg::AREA_W + 1;

  logic             en;
  logic [DEPTH-1:0] vpipe_r;
  logic             out_valid_r;
  logic [qah_pkg::AREA_W-1:0] area_r;

  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vpipe_r     <= {vpipe_r[DEPTH-2:0], in_valid};
      out_valid_r <= vpipe_r[DEPTH-1];
    end
  end

  // input registers
  logic [C-1:0] x_r [4];
  logic [C-1:0] y_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= in_corner0_x[C-1:0];
      y_r[0] <= in_corner0_y[C-1:0];
      x_r[1] <= in_corner1_x[C-1:0];
      y_r[1] <= in_corner1_y[C-1:0];
      x_r[2] <= in_corner2_x[C-1:0];
      y_r[2] <= in_corner2_y[C-1:0];
      x_r[3] <= in_corner3_x[C-1:0];
      y_r[3] <= in_corner3_y[C-1:0];
    end
  end

  // squared side lengths: a1=01, b1=03, c1=13, a2=12, b2=23
  localparam int PA [5] = '{0, 0, 1, 1, 2};
  localparam int PB [5] = '{1, 3, 3, 2, 3};

  logic [2*C:0]    sq_r  [5];
  logic [SR-1:0]   side_w [5];

  for (genvar k = 0; k < 5; k++) begin : g_side
    logic [C-1:0]   dx, dy;
    logic [2*C-1:0] dx2, dy2;
    assign dx  = (x_r[PA[k]] >= x_r[PB[k]]) ? x_r[PA[k]] - x_r[PB[k]] : x_r[PB[k]] - x_r[PA[k]];
    assign dy  = (y_r[PA[k]] >= y_r[PB[k]]) ? y_r[PA[k]] - y_r[PB[k]] : y_r[PB[k]] - y_r[PA[k]];
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k] <= {1'b0, dx2} + {1'b0, dy2};
      end
    end

    qah_sqrt_chain #(.RW(SR)) u_side (
      .clk    (clk),
      .en     (en),
      .rad_i  ({1'b0, sq_r[k]}),
      .root_o (side_w[k])
    );
  end

  // per triangle: heron factors, products, area root
  logic [SR-1:0]   ta [2];
  logic [SR-1:0]   tb [2];
  logic [PR-1:0]   troot [2];

  assign ta[0] = side_w[0];
  assign tb[0] = side_w[1];
  assign ta[1] = side_w[3];
  assign tb[1] = side_w[4];

  for (genvar t = 0; t < 2; t++) begin : g_tri
    logic signed [FW:0] sa, sb, sc;
    logic signed [FW:0] f0, f1, f2, f3;
    logic [FW-1:0]      f_r [4];
    logic               neg_r, neg1_r, neg2_r;
    logic [PR-1:0]      p01_r, p23_r;
    logic [PR+FW-1:0]   plo_r, phi_r;
    logic [2*PR-1:0]    prod_r;

    assign sa = $signed({3'b000, ta[t]});
    assign sb = $signed({3'b000, tb[t]});
    assign sc = $signed({3'b000, side_w[2]});
    assign f0 = sa + sb + sc;
    assign f1 = -sa + sb + sc;
    assign f2 = sa - sb + sc;
    assign f3 = sa + sb - sc;

    always_ff @(posedge clk) begin
      if (en) begin
        f_r[0] <= f0[FW-1:0];
        f_r[1] <= f1[FW-1:0];
        f_r[2] <= f2[FW-1:0];
        f_r[3] <= f3[FW-1:0];
        neg_r  <= f1[FW] | f2[FW] | f3[FW];
        p01_r  <= f_r[0] * f_r[1];
        p23_r  <= f_r[2] * f_r[3];
        neg1_r <= neg_r;
        plo_r  <= p01_r * p23_r[FW-1:0];
        phi_r  <= p01_r * p23_r[PR-1:FW];
        neg2_r <= neg1_r;
        prod_r <= neg2_r ? '0 : ({{FW{1'b0}}, plo_r} + ({{FW{1'b0}}, phi_r} << FW));
      end
    end

    qah_sqrt_chain #(.RW(PR)) u_area (
      .clk    (clk),
      .en     (en),
      .rad_i  (prod_r),
      .root_o (troot[t])
    );
  end

  logic [SW-1:0] sum;
  assign sum = SW'(troot[0]) + SW'(troot[1]);

  always_ff @(posedge clk) begin
    if (en) begin
      area_r <= (sum > SW'(qah_pkg::AREA_MAX)) ? qah_pkg::AREA_MAX : sum[qah_pkg::AREA_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_area  = area_r;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int CB = qah_pkg::COORD_BITS_DEF;
  localparam int LATENCY = CB + 2 * (CB + 3) + 8;

  typedef struct {
    logic [qah_pkg::COORD_W-1:0] x [4];
    logic [qah_pkg::COORD_W-1:0] y [4];
  } quad_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [qah_pkg::COORD_W-1:0] in_corner0_x = '0, in_corner0_y = '0;
  logic [qah_pkg::COORD_W-1:0] in_corner1_x = '0, in_corner1_y = '0;
  logic [qah_pkg::COORD_W-1:0] in_corner2_x = '0, in_corner2_y = '0;
  logic [qah_pkg::COORD_W-1:0] in_corner3_x = '0, in_corner3_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [qah_pkg::AREA_W-1:0] out_area;

  logic [qah_pkg::AREA_W-1:0] area_fifo [$];
  int err_count = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 69;

  quad_area_heron dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_corner0_x, .in_corner0_y, .in_corner1_x, .in_corner1_y,
    .in_corner2_x, .in_corner2_y, .in_corner3_x, .in_corner3_y,
    .out_valid, .out_ready, .out_area
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n -= root + bit_v;
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic longint side(longint x0, longint y0, longint x1, longint y1);
    longint dx, dy;
    dx = x0 - x1;
    dy = y0 - y1;
    return longint'(isqrt(longint'(dx * dx + dy * dy)));
  endfunction

  function automatic longint unsigned heron(longint a, longint b, longint c);
    longint f0, f1, f2, f3;
    f0 = a + b + c;
    f1 = -a + b + c;
    f2 = a - b + c;
    f3 = a + b - c;
    if (f0 < 0 || f1 < 0 || f2 < 0 || f3 < 0) return 0;
    return isqrt(longint'(f0 * f1 * f2 * f3));
  endfunction

  function automatic logic [qah_pkg::AREA_W-1:0] quad_area(quad_t q);
    longint x [4], y [4];
    longint a1, b1, c1, a2, b2;
    longint unsigned sum;
    for (int k = 0; k < 4; k++) begin
      x[k] = q.x[k];
      y[k] = q.y[k];
    end
    a1 = side(x[0], y[0], x[1], y[1]);
    b1 = side(x[0], y[0], x[3], y[3]);
    c1 = side(x[1], y[1], x[3], y[3]);
    a2 = side(x[1], y[1], x[2], y[2]);
    b2 = side(x[2], y[2], x[3], y[3]);
    sum = heron(a1, b1, c1) + heron(a2, b2, c1);
    if (sum > qah_pkg::AREA_MAX) sum = qah_pkg::AREA_MAX;
    return sum[qah_pkg::AREA_W-1:0];
  endfunction

  task automatic report(string what, logic [qah_pkg::AREA_W-1:0] got,
                        logic [qah_pkg::AREA_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (area_fifo.size() == 0) report("unexpected word", out_area, '0);
      else begin
        logic [qah_pkg::AREA_W-1:0] want;
        want = area_fifo.pop_front();
        if (out_area !== want) report("area", out_area, want);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_quad(quad_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_corner0_x <= q.x[0]; in_corner0_y <= q.y[0];
    in_corner1_x <= q.x[1]; in_corner1_y <= q.y[1];
    in_corner2_x <= q.x[2]; in_corner2_y <= q.y[2];
    in_corner3_x <= q.x[3]; in_corner3_y <= q.y[3];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    area_fifo.push_back(quad_area(q));
  endtask

  function automatic quad_t make_quad(int x0, int y0, int x1, int y1,
                                      int x2, int y2, int x3, int y3);
    quad_t q;
    q.x[0] = qah_pkg::COORD_W'(x0); q.y[0] = qah_pkg::COORD_W'(y0);
    q.x[1] = qah_pkg::COORD_W'(x1); q.y[1] = qah_pkg::COORD_W'(y1);
    q.x[2] = qah_pkg::COORD_W'(x2); q.y[2] = qah_pkg::COORD_W'(y2);
    q.x[3] = qah_pkg::COORD_W'(x3); q.y[3] = qah_pkg::COORD_W'(y3);
    return q;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (area_fifo.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int m;
    m = (1 << qah_pkg::COORD_W) - 1;
    send_quad(make_quad(0, 0, 0, 0, 0, 0, 0, 0));
    send_quad(make_quad(m, m, m, m, m, m, m, m));
    send_quad(make_quad(0, 0, m, 0, m, m, 0, m));
    send_quad(make_quad(0, 0, 0, m, m, m, m, 0));
    send_quad(make_quad(0, 0, m, m, 0, m, m, 0));
    send_quad(make_quad(0, 0, 4, 4, 8, 8, 12, 12));
    send_quad(make_quad(0, 0, 1, 0, 1, 1, 0, 1));
    send_quad(make_quad(0, 0, 3, 1, 5, 2, 1, 0));
    send_quad(make_quad(0, 0, 7, 3, 14, 6, 2, 1));
    send_quad(make_quad(100, 100, 200, 100, 120, 120, 100, 200));
    send_quad(make_quad(m, 0, 0, m, m, 0, 0, m));
    send_quad(make_quad(5, 5, 5, 5, 900, 300, 5, 5));
    send_quad(make_quad(0, m, m, 0, 0, m, 0, 0));
    send_quad(make_quad(8191, 8192, 8192, 8191, 1, 16382, 16382, 1));
    // hold off until the pipeline is empty
    drain();
    send_quad(make_quad(0, 0, 2, 1, 4, 2, 6, 3));
  endtask

  task automatic test_random(int count);
    quad_t q;
    int sz;
    for (int i = 0; i < count; i++) begin
      sz = $urandom_range(3);
      for (int k = 0; k < 4; k++) begin
        case (sz)
          0: begin
            q.x[k] = qah_pkg::COORD_W'($urandom_range(15));
            q.y[k] = qah_pkg::COORD_W'($urandom_range(15));
          end
          1: begin
            q.x[k] = qah_pkg::COORD_W'(8000 + $urandom_range(400));
            q.y[k] = qah_pkg::COORD_W'(8000 + $urandom_range(400));
          end
          default: begin
            q.x[k] = qah_pkg::COORD_W'($urandom);
            q.y[k] = qah_pkg::COORD_W'($urandom);
          end
        endcase
      end
      if ($urandom_range(9) == 0) q.x[2] = q.x[1] + (q.x[3] - q.x[1]) / 2;
      send_quad(q);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250);
    send_idle_pct = 69;
    recv_idle_pct = 12;
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250);
    fork
      drain();
      begin
        repeat (200000) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (LATENCY + 10) @(posedge clk);
    if (err_count == 0 && area_fifo.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
